[design/l1_nearest_vector_search_defines.svh]
// assertion macros for the l1 nearest vector search block
// no dependencies; included by the checker module
`ifndef L1_NEAREST_VECTOR_SEARCH_DEFINES_SVH
`define L1_NEAREST_VECTOR_SEARCH_DEFINES_SVH

// same-cycle implication
`define L1NVS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("l1nvs: same-cycle check failed");

// next-cycle implication
`define L1NVS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("l1nvs: next-cycle check failed");

`endif

[design/l1nvs_pkg.sv]
// shared types and constants for the l1 nearest vector search block
// no dependencies; used by the top level and the checker
package l1nvs_pkg;

   localparam int CFG_W  = 11;
   localparam int IDX_W  = 16;
   localparam int DIST_W = 44;
   localparam int RSP_W  = 2 * IDX_W + 2 * DIST_W;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic {
      FUNC_PATTERN   = 1'b0,
      FUNC_CANDIDATE = 1'b1
   } func_type;

endpackage

[design/l1_nearest_vector_search.sv]
// l1 nearest vector search: pattern store, distance accumulator, best tracker
// depends on l1nvs_pkg
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata elem_value, tuser func, tlast last_candidate
//   rsp     | out | rsp_tvalid/rsp_tready | tdata cand/best index+distance, tlast search_done
//   csr     | in  | csr_valid/csr_ready   | csr_data dimension (always ready)
//
// one element per cycle while req_tready is high; a result leaves once the
// candidate's final element has passed memory read, accumulate and best compare
// the pattern memory has one write and one read port; the read is issued on
// the transfer, so a pattern write is always visible to a later candidate
// reset is synchronous; the pattern memory is not cleared
// req_tready drops only when a completed distance is blocked behind a full
// result register and a full compare stage
module l1_nearest_vector_search #(
   parameter int              MAX_DIM        = 1024,
   parameter int              ELEM_BITS      = 32,
   parameter longint unsigned MAX_CANDIDATES = 64'd65536
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((ELEM_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // elem_value
   input  logic                                   req_tuser,  // func
   input  logic                                   req_tlast,  // last_candidate
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // cand_index, cand_distance, best_index, best_distance
   output logic [l1nvs_pkg::RSP_W-1:0]            rsp_tdata,
   output logic                                   rsp_tlast,  // search_done
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [l1nvs_pkg::CFG_W-1:0]            csr_data   // dimension
);

   localparam int AW      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DCW     = (AW + 1 > l1nvs_pkg::CFG_W) ? AW + 1 : l1nvs_pkg::CFG_W;
   localparam int CW      = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int CW1     = CW + 1;
   localparam int DIFF_W  = ELEM_BITS + 1;
   localparam int SUM_W   = (DIFF_W + 1 > l1nvs_pkg::DIST_W + 1) ? DIFF_W + 1
                                                                 : l1nvs_pkg::DIST_W + 1;
   localparam int DIST_W  = l1nvs_pkg::DIST_W;
   localparam int IDX_W   = l1nvs_pkg::IDX_W;

   // pattern memory
   logic [ELEM_BITS-1:0] pat_mem [MAX_DIM];

   // configuration
   logic [l1nvs_pkg::CFG_W-1:0] dim_ff, dim_in;
   logic [DCW-1:0]              dim_ext, dim_eff;

   // stage 0: positions
   logic [AW-1:0]        pat_pos_ff, pat_pos_in;
   logic [AW-1:0]        elem_pos_ff, elem_pos_in;
   logic [DCW-1:0]       pat_inc, elem_inc;
   logic                 pat_wrap, elem_final;
   logic                 req_xfer, is_cand;
   logic [ELEM_BITS-1:0] req_elem;

   // stage 1: accumulate
   logic                 s1_valid_ff, s1_valid_in;
   logic [ELEM_BITS-1:0] s1_elem_ff, s1_pat_ff;
   logic                 s1_final_ff, s1_last_ff;
   logic                 s1_fire;
   logic [DIFF_W-1:0]    a_ext, b_ext, diff_raw, diff_abs;
   logic [SUM_W-1:0]     sum;
   logic [DIST_W-1:0]    acc_sat;
   logic [DIST_W-1:0]    acc_ff, acc_in;

   // stage 2: completed distance
   logic              s2_valid_ff, s2_valid_in;
   logic [DIST_W-1:0] s2_dist_ff;
   logic              s2_last_ff;
   logic              s2_fire, s2_free;

   // result stage and best tracking
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW1-1:0]    cnt_inc;
   logic [63:0]       cnt_wide;
   logic [IDX_W-1:0]  cnt_idx;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in, new_best_dist;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in, new_best_idx;
   logic              have_best_ff, have_best_in;
   logic              take;
   logic [IDX_W-1:0]  o_cand_idx_ff, o_best_idx_ff;
   logic [DIST_W-1:0] o_cand_dist_ff, o_best_dist_ff;
   logic              o_done_ff;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;
   assign dim_in    = csr_valid ? csr_data : dim_ff;

   always_comb begin
      dim_ext = DCW'(dim_ff);
      if (dim_ext == '0) begin
         dim_eff = DCW'(1);
      end else if (dim_ext > DCW'(MAX_DIM)) begin
         dim_eff = DCW'(MAX_DIM);
      end else begin
         dim_eff = dim_ext;
      end
   end

   // ---------------- stage 0 ----------------
   assign req_xfer = req_tvalid & req_tready;
   assign is_cand  = (l1nvs_pkg::func_type'(req_tuser) == l1nvs_pkg::FUNC_CANDIDATE);
   assign req_elem = req_tdata[ELEM_BITS-1:0];

   // a position at or past the dimension counts as the final one
   assign pat_inc    = DCW'(pat_pos_ff) + DCW'(1);
   assign pat_wrap   = (pat_inc >= dim_eff);
   assign elem_inc   = DCW'(elem_pos_ff) + DCW'(1);
   assign elem_final = (elem_inc >= dim_eff);

   always_comb begin
      pat_pos_in  = pat_pos_ff;
      elem_pos_in = elem_pos_ff;
      if (req_xfer && !is_cand) begin
         pat_pos_in = pat_wrap ? '0 : pat_inc[AW-1:0];
      end
      if (req_xfer && is_cand) begin
         elem_pos_in = elem_final ? '0 : elem_inc[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && !is_cand) begin
         pat_mem[pat_pos_ff] <= req_elem;
      end
      if (req_xfer && is_cand) begin
         s1_pat_ff <= pat_mem[elem_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && is_cand) begin
         s1_elem_ff  <= req_elem;
         s1_final_ff <= elem_final;
         s1_last_ff  <= req_tlast;
      end
   end

   // ---------------- stage 1 ----------------
   assign s1_fire    = s1_valid_ff && (!s1_final_ff || s2_free);
   assign req_tready = !s1_valid_ff || s1_fire;

   always_comb begin
      if (req_xfer && is_cand) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign a_ext    = {s1_elem_ff[ELEM_BITS-1], s1_elem_ff};
   assign b_ext    = {s1_pat_ff[ELEM_BITS-1], s1_pat_ff};
   assign diff_raw = a_ext - b_ext;
   assign diff_abs = diff_raw[DIFF_W-1] ? (~diff_raw + DIFF_W'(1)) : diff_raw;
   assign sum      = SUM_W'(acc_ff) + SUM_W'(diff_abs);
   assign acc_sat  = (sum >= SUM_W'(l1nvs_pkg::DIST_MAX)) ? l1nvs_pkg::DIST_MAX
                                                          : sum[DIST_W-1:0];

   always_comb begin
      acc_in = acc_ff;
      if (s1_fire) begin
         acc_in = s1_final_ff ? '0 : acc_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_final_ff) begin
         s2_dist_ff <= acc_sat;
         s2_last_ff <= s1_last_ff;
      end
   end

   // ---------------- stage 2 ----------------
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s2_fire  = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;

   always_comb begin
      if (s1_fire && s1_final_ff) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   // ---------------- best tracking and result ----------------
   assign cnt_inc  = {1'b0, cnt_ff} + CW1'(1);
   assign cnt_wide = 64'(cnt_ff);
   assign cnt_idx  = cnt_wide[IDX_W-1:0];

   // strictly smaller replaces, so the first of equal distances stays
   assign take          = !have_best_ff || (s2_dist_ff < best_dist_ff);
   assign new_best_dist = take ? s2_dist_ff : best_dist_ff;
   assign new_best_idx  = take ? cnt_idx : best_idx_ff;

   always_comb begin
      cnt_in       = cnt_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      have_best_in = have_best_ff;
      if (s2_fire) begin
         if (s2_last_ff) begin
            cnt_in       = '0;
            best_dist_in = '0;
            best_idx_in  = '0;
            have_best_in = 1'b0;
         end else begin
            cnt_in       = (cnt_inc == CW1'(MAX_CANDIDATES)) ? '0 : cnt_inc[CW-1:0];
            best_dist_in = new_best_dist;
            best_idx_in  = new_best_idx;
            have_best_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (s2_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         o_cand_idx_ff  <= cnt_idx;
         o_cand_dist_ff <= s2_dist_ff;
         o_best_idx_ff  <= new_best_idx;
         o_best_dist_ff <= new_best_dist;
         o_done_ff      <= s2_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {o_best_dist_ff, o_best_idx_ff, o_cand_dist_ff, o_cand_idx_ff};
   assign rsp_tlast  = o_done_ff;

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= l1nvs_pkg::CFG_W'(1);
         pat_pos_ff   <= '0;
         elem_pos_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         best_dist_ff <= '0;
         best_idx_ff  <= '0;
         have_best_ff <= 1'b0;
      end else begin
         dim_ff       <= dim_in;
         pat_pos_ff   <= pat_pos_in;
         elem_pos_ff  <= elem_pos_in;
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         best_dist_ff <= best_dist_in;
         best_idx_ff  <= best_idx_in;
         have_best_ff <= have_best_in;
      end
   end

endmodule

[design/l1nvs_checker.sv]
// port-level checks for the l1 nearest vector search block, with its bind
// depends on l1nvs_pkg and l1_nearest_vector_search_defines.svh
`include "l1_nearest_vector_search_defines.svh"

module l1nvs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [l1nvs_pkg::RSP_W-1:0] rsp_tdata,
   input logic                        rsp_tlast
);

   localparam int IDX_W  = l1nvs_pkg::IDX_W;
   localparam int DIST_W = l1nvs_pkg::DIST_W;

   logic [IDX_W-1:0]          cand_idx, best_idx;
   logic [DIST_W-1:0]         cand_dist, best_dist;
   logic                      first_ff, first_in;
   logic                      rsp_stall, first_ok;
   logic [l1nvs_pkg::RSP_W:0] rsp_word;

   assign cand_idx  = rsp_tdata[IDX_W-1:0];
   assign cand_dist = rsp_tdata[IDX_W+DIST_W-1:IDX_W];
   assign best_idx  = rsp_tdata[2*IDX_W+DIST_W-1:IDX_W+DIST_W];
   assign best_dist = rsp_tdata[2*IDX_W+2*DIST_W-1:2*IDX_W+DIST_W];

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_word  = {rsp_tlast, rsp_tdata};
   assign first_ok  = (cand_idx == '0) && (best_idx == cand_idx) && (best_dist == cand_dist);

   // set until the first result of a search has been transferred
   assign first_in = (rsp_tvalid && rsp_tready) ? rsp_tlast : first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else begin
         first_ff <= first_in;
      end
   end

   `L1NVS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))
   `L1NVS_ASSERT_IMP(a_best_not_worse, clock, reset, rsp_tvalid, best_dist <= cand_dist)
   `L1NVS_ASSERT_IMP(a_first_is_best, clock, reset, rsp_tvalid && first_ff, first_ok)
   `L1NVS_ASSERT_IMP(a_stall_cause, clock, reset, !req_tready, rsp_stall)

endmodule

bind l1_nearest_vector_search l1nvs_checker u_l1nvs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/l1_nearest_vector_search_tb.sv]
// testbench for the l1 nearest vector search block: directed and random vector streams
// against an in-bench model of the distance search; depends on l1nvs_pkg and the rtl
module l1_nearest_vector_search_tb;

   localparam int              IDX_W      = l1nvs_pkg::IDX_W;
   localparam int              DIST_W     = l1nvs_pkg::DIST_W;
   localparam int              RSP_W      = l1nvs_pkg::RSP_W;
   localparam int              CFG_W      = l1nvs_pkg::CFG_W;
   localparam int              DIM_LIMIT  = 1024;
   localparam longint unsigned DIST_LIMIT = (64'd1 << DIST_W) - 1;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [IDX_W-1:0]  cand_index;
      logic [DIST_W-1:0] cand_distance;
      logic [IDX_W-1:0]  best_index;
      logic [DIST_W-1:0] best_distance;
      logic              search_done;
   } search_result_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [31:0]      req_tdata;
   logic             req_tuser;
   logic             req_tlast;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data;

   // model of the search
   logic [31:0]       pat_mem [DIM_LIMIT];
   int unsigned       pat_pos    = 0;
   int unsigned       elem_pos   = 0;
   longint unsigned   dist_acc   = 0;
   logic [IDX_W-1:0]  cand_cnt   = '0;
   longint unsigned   best_dist  = 0;
   logic [IDX_W-1:0]  best_idx   = '0;
   bit                best_valid = 1'b0;
   logic [CFG_W-1:0]  dim_reg    = 11'd1;

   search_result_type due_results [$];
   int unsigned       mismatches   = 0;
   int unsigned       tx_idle_pct  = 0;
   int unsigned       rx_stall_pct = 0;
   int unsigned       cands_left   = 3;

   l1_nearest_vector_search u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
   end

   function automatic int unsigned active_dim();
      if (dim_reg == 0) return 1;
      if (dim_reg > DIM_LIMIT) return DIM_LIMIT;
      return 32'(dim_reg);
   endfunction

   // apply one accepted item to the model, queue the result it completes
   function automatic void advance_search(input l1nvs_pkg::func_type f, input logic [31:0] v,
                                          input logic l);
      int unsigned       d;
      int unsigned       p;
      int unsigned       e;
      longint            a;
      longint            b;
      longint unsigned   diff;
      search_result_type r;
      d = active_dim();
      if (f == l1nvs_pkg::FUNC_PATTERN) begin
         p = (pat_pos < DIM_LIMIT) ? pat_pos : 0;
         pat_mem[p] = v;
         pat_pos = (p + 1 >= d) ? 0 : p + 1;
      end else begin
         e = (elem_pos < DIM_LIMIT) ? elem_pos : 0;
         a = longint'($signed(v));
         b = longint'($signed(pat_mem[e]));
         diff = (a >= b) ? longint'(a - b) : longint'(b - a);
         if (diff >= DIST_LIMIT - dist_acc) dist_acc = DIST_LIMIT;
         else dist_acc = dist_acc + diff;
         if (e + 1 < d) begin
            elem_pos = e + 1;
         end else begin
            // strictly smaller replaces, so the first of equal candidates stays
            if (!best_valid || dist_acc < best_dist) begin
               best_dist  = dist_acc;
               best_idx   = cand_cnt;
               best_valid = 1'b1;
            end
            r.cand_index    = cand_cnt;
            r.cand_distance = dist_acc[DIST_W-1:0];
            r.best_index    = best_idx;
            r.best_distance = best_dist[DIST_W-1:0];
            r.search_done   = l;
            due_results.push_back(r);
            elem_pos = 0;
            dist_acc = 0;
            cand_cnt = cand_cnt + 1'b1;
            if (l) begin
               cand_cnt   = '0;
               best_dist  = 0;
               best_idx   = '0;
               best_valid = 1'b0;
            end
         end
      end
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input longint unsigned got,
                              input longint unsigned want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   task automatic check_result();
      search_result_type want;
      if (due_results.size() == 0) begin
         report_mismatch("result with nothing due, cand_index",
                         64'(rsp_tdata[IDX_W-1:0]), 64'd0);
      end else begin
         want = due_results.pop_front();
         check_field("cand_index", 64'(rsp_tdata[IDX_W-1:0]), 64'(want.cand_index));
         check_field("cand_distance", 64'(rsp_tdata[IDX_W+DIST_W-1:IDX_W]),
                     64'(want.cand_distance));
         check_field("best_index", 64'(rsp_tdata[2*IDX_W+DIST_W-1:IDX_W+DIST_W]),
                     64'(want.best_index));
         check_field("best_distance", 64'(rsp_tdata[RSP_W-1:2*IDX_W+DIST_W]),
                     64'(want.best_distance));
         check_field("search_done", 64'(rsp_tlast), 64'(want.search_done));
      end
   endtask

   // model first, so an item and a result in the same cycle stay in order
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) dim_reg = csr_data;
         if (req_tvalid && req_tready)
            advance_search(l1nvs_pkg::func_type'(req_tuser), req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   task automatic set_idling(input idle_mode_type mode);
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      case (mode)
         IDLE_SENDER: begin
            tx_idle_pct = 61;
         end
         IDLE_RECEIVER: begin
            rx_stall_pct = 61;
         end
         IDLE_BOTH: begin
            tx_idle_pct  = 33;
            rx_stall_pct = 33;
         end
         default: begin
         end
      endcase
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input l1nvs_pkg::func_type f, input logic [31:0] v,
                            input logic l);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= v;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // only once the block has drained
   task automatic write_dimension(input logic [CFG_W-1:0] value);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_value(input int unsigned pos);
      case ($urandom_range(9))
         0, 1:    return pat_mem[pos];
         2, 3:    return pat_mem[pos] + 32'($urandom_range(64)) - 32'd32;
         4:       return 32'h8000_0000;
         5:       return 32'h7FFF_FFFF;
         6:       return {32{1'($urandom_range(1))}};
         default: return $urandom();
      endcase
   endfunction

   task automatic test_directed_search();
      write_dimension(11'd2);
      // extremes as pattern, flag on pattern elements is ignored
      send_item(l1nvs_pkg::FUNC_PATTERN, 32'h7FFF_FFFF, 1'b1);
      send_item(l1nvs_pkg::FUNC_PATTERN, 32'h8000_0000, 1'b0);
      // farthest possible candidate, flag on a non-final element ignored
      send_item(l1nvs_pkg::FUNC_CANDIDATE, 32'h8000_0000, 1'b1);
      send_item(l1nvs_pkg::FUNC_CANDIDATE, 32'h7FFF_FFFF, 1'b0);
      // exact match, with a pattern write in the middle of it
      send_item(l1nvs_pkg::FUNC_CANDIDATE, 32'h7FFF_FFFF, 1'b0);
      send_item(l1nvs_pkg::FUNC_PATTERN, 32'h0001_0000, 1'b0);
      send_item(l1nvs_pkg::FUNC_CANDIDATE, 32'h8000_0000, 1'b0);
      // equal distance, earlier best must stay; ends the search
      send_item(l1nvs_pkg::FUNC_CANDIDATE, 32'h0001_0000, 1'b0);
      send_item(l1nvs_pkg::FUNC_CANDIDATE, 32'h8000_0000, 1'b1);
   endtask

   task automatic test_dimension_edges();
      // zero acts as one
      write_dimension(11'd0);
      send_item(l1nvs_pkg::FUNC_PATTERN, 32'hFFFF_FFFF, 1'b0);
      send_item(l1nvs_pkg::FUNC_CANDIDATE, 32'h0000_0000, 1'b0);
      send_item(l1nvs_pkg::FUNC_CANDIDATE, 32'hFFFF_0000, 1'b1);
      // shrink the dimension in the middle of a vector
      write_dimension(11'd3);
      repeat (5) send_item(l1nvs_pkg::FUNC_PATTERN, $urandom(), 1'b0);
      send_item(l1nvs_pkg::FUNC_CANDIDATE, $urandom(), 1'b0);
      send_item(l1nvs_pkg::FUNC_CANDIDATE, $urandom(), 1'b0);
      write_dimension(11'd2);
      send_item(l1nvs_pkg::FUNC_CANDIDATE, $urandom(), 1'b1);
      send_item(l1nvs_pkg::FUNC_PATTERN, $urandom(), 1'b0);
   endtask

   task automatic test_full_dimension();
      write_dimension(11'd1024);
      set_idling(IDLE_BOTH);
      repeat (DIM_LIMIT)
         send_item(l1nvs_pkg::FUNC_PATTERN, $urandom(), 1'($urandom_range(1)));
      // above the maximum acts as the maximum
      write_dimension(11'd2047);
      repeat (DIM_LIMIT)
         send_item(l1nvs_pkg::FUNC_CANDIDATE,
                   pat_mem[elem_pos][31] ? 32'h7FFF_FFFF : 32'h8000_0000, 1'b0);
   endtask

   task automatic test_random_search(input int unsigned n_items);
      int unsigned       r;
      logic [CFG_W-1:0]  dim;
      logic              l;
      for (int phase = 0; phase < 16; phase++) begin
         r = $urandom_range(99);
         if (r < 60)      dim = CFG_W'($urandom_range(1, 4));
         else if (r < 80) dim = CFG_W'($urandom_range(5, 16));
         else if (r < 88) dim = CFG_W'($urandom_range(17, 64));
         else if (r < 92) dim = '0;
         else if (r < 95) dim = '1;
         else if (r < 97) dim = 11'd1024;
         else             dim = CFG_W'($urandom_range(1025, 2046));
         write_dimension(dim);
         set_idling(idle_mode_type'(phase % 4));
         repeat (n_items / 16) begin
            if ($urandom_range(99) < 8) begin
               send_item(l1nvs_pkg::FUNC_PATTERN, $urandom(), 1'($urandom_range(1)));
            end else if (elem_pos + 1 >= active_dim()) begin
               // final element; now and then a search is cut short
               l = (cands_left <= 1) || ($urandom_range(99) < 3);
               cands_left = l ? $urandom_range(1, 8) : cands_left - 1;
               send_item(l1nvs_pkg::FUNC_CANDIDATE, pick_value(elem_pos), l);
            end else begin
               send_item(l1nvs_pkg::FUNC_CANDIDATE, pick_value(elem_pos),
                         1'($urandom_range(99) < 15));
            end
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      rsp_tready = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_search();
      test_dimension_edges();
      test_full_dimension();
      test_random_search(320);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("l1_nearest_vector_search_tb OK");
      end else begin
         $display("l1_nearest_vector_search_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("l1_nearest_vector_search_tb NOT OK");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/l1nvs_pkg.sv
design/l1_nearest_vector_search.sv
design/l1nvs_checker.sv
tb/l1_nearest_vector_search_tb.sv
